// ===== sv/rsmp_pkg.sv =====
// ---------------------------------------------------------------------------
// rsmp_pkg
// Shared types and constants of the nearest-neighbour resampler.
// ---------------------------------------------------------------------------
package rsmp_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int STEP_FRAC      = 16;
   localparam int STEP_BITS      = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int QUEUE_DEPTH    = 4;

   // register map of the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_COUNT  = CSR_INDEX_BITS'(0),
      CSR_OUT_COUNT = CSR_INDEX_BITS'(1),
      CSR_GAIN      = CSR_INDEX_BITS'(2)
   } csr_index_type;

   // effective configuration, counts already forced to at least one
   typedef struct packed {
      logic [COUNT_BITS-1:0] in_count;
      logic [COUNT_BITS-1:0] out_count;
      logic [GAIN_BITS-1:0]  gain;
   } cfg_type;

   // classification of one source sample, passed from front to back
   typedef struct packed {
      logic                  run_start;
      logic [COUNT_BITS-1:0] in_index;
   } tag_type;

endpackage

// ===== sv/rsmp_if.sv =====
// ---------------------------------------------------------------------------
// rsmp_req_if / rsmp_rsp_if
// Valid/ready channels carrying source samples in and resampled results out.
// ---------------------------------------------------------------------------
interface rsmp_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface rsmp_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          last_of_run;

   modport source (output valid, output out_sample, output last_of_run, input ready);
   modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

// ===== sv/rsmp_fifo.sv =====
// ---------------------------------------------------------------------------
// rsmp_fifo
// Small first-in first-out queue between the front and the back part.
// ---------------------------------------------------------------------------
module rsmp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/rsmp_front.sv =====
// ---------------------------------------------------------------------------
// rsmp_front
// Accepts source samples, applies gain with rounding and saturation, tracks
// the position within the run and pushes tagged samples into the queue.
// ---------------------------------------------------------------------------
module rsmp_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsmp_pkg::cfg_type      cfg,
   rsmp_req_if.sink               req_ch,
   input  logic                   q_full,
   output logic                   q_push,
   output rsmp_pkg::tag_type      q_tag,
   output logic [SAMPLE_BITS-1:0] q_sample
);

   localparam int PROD_BITS  = SAMPLE_BITS + rsmp_pkg::GAIN_BITS + 1;
   localparam int QUOT_BITS  = PROD_BITS - rsmp_pkg::GAIN_FRAC;
   localparam int ROUND_HALF = 1 << (rsmp_pkg::GAIN_FRAC - 1);

   logic [rsmp_pkg::COUNT_BITS-1:0] in_idx_ff, in_idx_in;
   logic [rsmp_pkg::COUNT_BITS:0]   idx_inc;
   logic signed [SAMPLE_BITS-1:0]   in_s;
   logic signed [PROD_BITS-1:0]     prod;
   logic signed [PROD_BITS-1:0]     prod_rnd;
   logic [QUOT_BITS-1:0]            quot;
   logic                            ovf;

   // transfer whenever the queue has room
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // gain, round half up, floor shift
   assign in_s     = req_ch.in_sample;
   assign prod     = in_s * $signed({1'b0, cfg.gain});
   assign prod_rnd = prod + PROD_BITS'(ROUND_HALF);
   assign quot     = prod_rnd[PROD_BITS-1:rsmp_pkg::GAIN_FRAC];

   // saturate to the sample width
   assign ovf = !((&quot[QUOT_BITS-1:SAMPLE_BITS-1]) || !(|quot[QUOT_BITS-1:SAMPLE_BITS-1]));

   always_comb begin
      if (ovf) begin
         q_sample = quot[QUOT_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         q_sample = quot[SAMPLE_BITS-1:0];
      end
   end

   // source index within the run
   assign idx_inc         = {1'b0, in_idx_ff} + 1'b1;
   assign in_idx_in       = (idx_inc >= {1'b0, cfg.in_count}) ? '0
                                                              : idx_inc[rsmp_pkg::COUNT_BITS-1:0];
   assign q_tag.run_start = (in_idx_ff == '0);
   assign q_tag.in_index  = in_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_idx_ff <= '0;
      end else if (q_push) begin
         in_idx_ff <= in_idx_in;
      end
   end

endmodule

// ===== sv/rsmp_div.sv =====
// ---------------------------------------------------------------------------
// rsmp_div
// Restoring divider for the 16.16 step, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsmp_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rsmp_pkg::STEP_BITS-1:0]      dividend,
   input  logic [rsmp_pkg::COUNT_BITS-1:0]     divisor,
   output logic                                done,
   output logic [rsmp_pkg::STEP_BITS-1:0]      quotient
);

   localparam int CNT_BITS = $clog2(rsmp_pkg::STEP_BITS);
   localparam int CB       = rsmp_pkg::COUNT_BITS;
   localparam int SB       = rsmp_pkg::STEP_BITS;

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [SB-1:0]       quo_ff;
   logic [CB-1:0]       rem_ff;
   logic [CB-1:0]       div_ff;
   logic [CB:0]         rem_sh;
   logic [CB:0]         rem_diff;
   logic                fits;

   // one trial subtraction per cycle
   assign rem_sh   = {rem_ff, quo_ff[SB-1]};
   assign fits     = (rem_sh >= {1'b0, div_ff});
   assign rem_diff = rem_sh - {1'b0, div_ff};

   assign done     = done_ff;
   assign quotient = quo_ff;

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SB-2:0], fits};
         rem_ff <= fits ? rem_diff[CB-1:0] : rem_sh[CB-1:0];
      end
   end

endmodule

// ===== sv/rsmp_back.sv =====
// ---------------------------------------------------------------------------
// rsmp_back
// Takes tagged samples from the queue, works out the step at run start and
// emits the repeated, picked outputs through a registered result stage.
// ---------------------------------------------------------------------------
module rsmp_back #(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_RATIO   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsmp_pkg::cfg_type      cfg,
   input  logic                   q_empty,
   input  rsmp_pkg::tag_type      q_tag,
   input  logic [SAMPLE_BITS-1:0] q_sample,
   output logic                   q_pop,
   rsmp_rsp_if.source             rsp_ch
);

   localparam int BURST_BITS = $clog2(MAX_RATIO + 1);
   localparam int CB         = rsmp_pkg::COUNT_BITS;
   localparam int SB         = rsmp_pkg::STEP_BITS;

   typedef enum logic [1:0] {
      ST_PICK,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic [SB-1:0]          step_ff;
   logic [SB-1:0]          pos_ff;
   logic [CB-1:0]          out_idx_ff;
   logic [BURST_BITS-1:0]  burst_ff;
   logic [SAMPLE_BITS-1:0] out_sample_ff;
   logic                   out_last_ff;
   logic                   out_valid_ff;

   logic [SB-1:0]          pos_in;
   logic [CB-1:0]          idx_in;
   logic                   can_out;
   logic                   more;
   logic                   more_after;
   logic                   emit;
   logic                   div_start;
   logic                   div_done;
   logic [SB-1:0]          div_quot;

   // step division at run start
   assign div_start = (state_ff == ST_PICK) && !q_empty && q_tag.run_start;

   rsmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cfg.in_count, {rsmp_pkg::STEP_FRAC{1'b0}}}),
      .divisor  (cfg.out_count),
      .done     (div_done),
      .quotient (div_quot)
   );

   // pick condition now and after this output
   assign pos_in     = pos_ff + step_ff;
   assign idx_in     = out_idx_ff + 1'b1;
   assign can_out    = !out_valid_ff || rsp_ch.ready;
   assign more       = (burst_ff < BURST_BITS'(MAX_RATIO)) &&
                       (out_idx_ff < cfg.out_count) &&
                       (pos_ff[SB-1:rsmp_pkg::STEP_FRAC] <= q_tag.in_index);
   assign more_after = ((burst_ff + 1'b1) < BURST_BITS'(MAX_RATIO)) &&
                       (idx_in < cfg.out_count) &&
                       (pos_in[SB-1:rsmp_pkg::STEP_FRAC] <= q_tag.in_index);
   assign emit       = (state_ff == ST_EMIT) && more && can_out;
   assign q_pop      = (state_ff == ST_EMIT) && ((emit && !more_after) || !more);

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.out_sample  = out_sample_ff;
   assign rsp_ch.last_of_run = out_last_ff;

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PICK;
         step_ff      <= '0;
         pos_ff       <= '0;
         out_idx_ff   <= '0;
         burst_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= emit || (out_valid_ff && !rsp_ch.ready);
         case (state_ff)
            ST_PICK: begin
               if (!q_empty) begin
                  burst_ff <= '0;
                  state_ff <= q_tag.run_start ? ST_STEP : ST_EMIT;
               end
            end
            ST_STEP: begin
               if (div_done) begin
                  step_ff    <= div_quot;
                  pos_ff     <= '0;
                  out_idx_ff <= '0;
                  state_ff   <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit) begin
                  out_sample_ff <= q_sample;
                  out_last_ff   <= (out_idx_ff == cfg.out_count - CB'(1));
                  pos_ff        <= pos_in;
                  out_idx_ff    <= idx_in;
                  burst_ff      <= burst_ff + 1'b1;
               end
               if (q_pop) begin
                  state_ff <= ST_PICK;
               end
            end
            default: begin
               state_ff <= ST_PICK;
            end
         endcase
      end
   end

endmodule

// ===== sv/nearest_neighbor_resampler.sv =====
// ---------------------------------------------------------------------------
// nearest_neighbor_resampler
// Nearest-neighbour resampler of a run of source samples with Q4.12 gain.
// ---------------------------------------------------------------------------
// Source samples arrive on req_ch and results leave on rsp_ch, both
// valid/ready; a transfer happens when valid and ready are both high.
// in_count, out_count and gain are written on the csr port (index 0, 1, 2);
// the user must write them only while the block is idle, which the block
// itself does not enforce. Each source sample gives zero or more results,
// the final output of a run carries last_of_run. A source sample passes
// through the queue, the pick state and the result register; the first
// sample of a run also waits for the bit-serial step divider (one quotient
// bit per cycle, 32 bits). The back part gives one result per cycle while
// the receiver is ready and finishes each source sample before the next.
// A 4-entry queue lets the front keep taking samples while the back works.
// Reset (synchronous) restores in_count = out_count = 1, unity gain, and
// starts a fresh run. When the receiver stalls the result register holds,
// the back part waits and the queue fills, then req_ch.ready drops.
// ---------------------------------------------------------------------------
module nearest_neighbor_resampler #(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_RATIO   = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rsmp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rsmp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   rsmp_req_if.sink                             req_ch,
   rsmp_rsp_if.source                           rsp_ch
);

   localparam int CB       = rsmp_pkg::COUNT_BITS;
   localparam int TAG_BITS = $bits(rsmp_pkg::tag_type);
   localparam int Q_BITS   = TAG_BITS + SAMPLE_BITS;

   logic [CB-1:0]                  in_count_ff;
   logic [CB-1:0]                  out_count_ff;
   logic [rsmp_pkg::GAIN_BITS-1:0] gain_ff;
   rsmp_pkg::cfg_type              cfg;

   logic                   q_push, q_full, q_pop, q_empty;
   rsmp_pkg::tag_type      push_tag, pop_tag;
   logic [SAMPLE_BITS-1:0] push_sample, pop_sample;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= CB'(1);
         out_count_ff <= CB'(1);
         gain_ff      <= rsmp_pkg::GAIN_BITS'(1 << rsmp_pkg::GAIN_FRAC);
      end else if (csr_we) begin
         case (rsmp_pkg::csr_index_type'(csr_index))
            rsmp_pkg::CSR_IN_COUNT:  in_count_ff  <= csr_wdata[CB-1:0];
            rsmp_pkg::CSR_OUT_COUNT: out_count_ff <= csr_wdata[CB-1:0];
            rsmp_pkg::CSR_GAIN:      gain_ff      <= csr_wdata[rsmp_pkg::GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // a zero count acts as one
   assign cfg.in_count  = (in_count_ff == '0) ? CB'(1) : in_count_ff;
   assign cfg.out_count = (out_count_ff == '0) ? CB'(1) : out_count_ff;
   assign cfg.gain      = gain_ff;

   rsmp_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_tag    (push_tag),
      .q_sample (push_sample)
   );

   rsmp_fifo #(
      .WIDTH (Q_BITS),
      .DEPTH (rsmp_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_tag, push_sample}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  ({pop_tag, pop_sample}),
      .empty     (q_empty)
   );

   rsmp_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_RATIO   (MAX_RATIO)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_empty  (q_empty),
      .q_tag    (pop_tag),
      .q_sample (pop_sample),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== tb/tb_nearest_neighbor_resampler.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_resampler
// Self-checking bench for the nearest-neighbour resampler. A directed table
// covers sample extremes, saturation, rounding ties, zero counts, the ratio
// limit and counts changed mid-run. Randomised phases of runs follow, under
// varying register settings and handshake idling. Every result is compared
// in order with a table value or the output of a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_resampler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 24;
   localparam int MAX_RATIO     = 64;
   localparam int ITEMS_WANTED  = 500;
   localparam int SETTLE_CYCLES = 80;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int HOLD_CYCLES   = 500;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          last;
   } output_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                           kind;
      rsmp_pkg::csr_index_type                reg_index;
      logic [rsmp_pkg::CSR_DATA_BITS-1:0]     wdata;
      logic signed [SAMPLE_BITS-1:0]          sample;
      logic                                   typed;
      output_type                             typed_out;
   } row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we;
   logic [rsmp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rsmp_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   rsmp_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   rsmp_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();

   nearest_neighbor_resampler #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_RATIO  (MAX_RATIO)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   // predictor copy of the registers and the run state
   logic [rsmp_pkg::COUNT_BITS-1:0] cfg_in_count  = 16'd1;
   logic [rsmp_pkg::COUNT_BITS-1:0] cfg_out_count = 16'd1;
   logic [rsmp_pkg::GAIN_BITS-1:0]  cfg_gain      = 16'd4096;
   logic [rsmp_pkg::STEP_BITS-1:0]  run_step      = '0;
   logic [rsmp_pkg::STEP_BITS-1:0]  run_pos       = '0;
   logic [rsmp_pkg::COUNT_BITS-1:0] run_out_done  = '0;
   logic [rsmp_pkg::COUNT_BITS-1:0] run_src_index = '0;

   output_type owed_outputs[$];
   int         mismatch_count = 0;
   int         items_sent     = 0;
   int         send_idle_pct  = 0;
   int         rsp_stall_pct  = 0;
   int         hold_requests  = 0;
   bit         rsp_hold;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // table rows
   function automatic row_type sample_row(input logic signed [SAMPLE_BITS-1:0] s);
      row_type r;
      r        = '0;
      r.kind   = ROW_SAMPLE;
      r.sample = s;
      return r;
   endfunction

   function automatic row_type known_row(input logic signed [SAMPLE_BITS-1:0] s,
                                         input logic signed [SAMPLE_BITS-1:0] v,
                                         input logic last);
      row_type r;
      r                 = sample_row(s);
      r.typed           = 1'b1;
      r.typed_out.value = v;
      r.typed_out.last  = last;
      return r;
   endfunction

   function automatic row_type write_row(input rsmp_pkg::csr_index_type idx,
                                         input logic [rsmp_pkg::CSR_DATA_BITS-1:0] v);
      row_type r;
      r           = '0;
      r.kind      = ROW_WRITE;
      r.reg_index = idx;
      r.wdata     = v;
      return r;
   endfunction

   // sample times Q4.12 gain, round half up, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] scale_by_gain(
         input logic signed [SAMPLE_BITS-1:0] s,
         input logic [rsmp_pkg::GAIN_BITS-1:0] g);
      longint prod;
      prod = longint'(s) * longint'(g) + (longint'(1) << (rsmp_pkg::GAIN_FRAC - 1));
      prod = prod >>> rsmp_pkg::GAIN_FRAC;
      if (prod > SAMPLE_MAX) prod = SAMPLE_MAX;
      if (prod < SAMPLE_MIN) prod = SAMPLE_MIN;
      return SAMPLE_BITS'(prod);
   endfunction

   // nearest-neighbour picks caused by one source sample
   task automatic resample_one(input logic signed [SAMPLE_BITS-1:0] s, input bit record);
      logic [rsmp_pkg::COUNT_BITS-1:0] ic;
      logic [rsmp_pkg::COUNT_BITS-1:0] oc;
      logic signed [SAMPLE_BITS-1:0]   scaled;
      int                              n;
      output_type                      o;
      ic     = (cfg_in_count == '0) ? 16'd1 : cfg_in_count;
      oc     = (cfg_out_count == '0) ? 16'd1 : cfg_out_count;
      scaled = scale_by_gain(s, cfg_gain);
      // first sample of a run latches the step
      if (run_src_index == '0) begin
         run_step     = (rsmp_pkg::STEP_BITS'(ic) << rsmp_pkg::STEP_FRAC) /
                        rsmp_pkg::STEP_BITS'(oc);
         run_pos      = '0;
         run_out_done = '0;
      end
      n = 0;
      while (n < MAX_RATIO && run_out_done < oc &&
             (run_pos >> rsmp_pkg::STEP_FRAC) <= run_src_index) begin
         o.value = scaled;
         o.last  = (run_out_done == oc - 16'd1);
         if (record) owed_outputs.push_back(o);
         run_out_done = run_out_done + 16'd1;
         run_pos      = run_pos + run_step;
         n++;
      end
      if (32'(run_src_index) + 1 >= 32'(ic)) run_src_index = '0;
      else run_src_index = run_src_index + 16'd1;
   endtask

   // one register write, only while idle
   task automatic write_reg(input rsmp_pkg::csr_index_type idx,
                            input logic [rsmp_pkg::CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         rsmp_pkg::CSR_IN_COUNT:  cfg_in_count  = v;
         rsmp_pkg::CSR_OUT_COUNT: cfg_out_count = v;
         rsmp_pkg::CSR_GAIN:      cfg_gain      = v;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offer one source sample and wait for its transfer
   task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit typed,
                               input output_type typed_out);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.in_sample <= s;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      resample_one(s, !typed);
      if (typed) owed_outputs.push_back(typed_out);
      items_sent++;
   endtask

   // stop offering, collect what is owed, let the divider settle
   task automatic drain_outputs();
      int waited;
      waited = 0;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (owed_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver ready, random stalls and the long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !reset && !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long hold-off, counted in cycles
   initial begin : hold_off
      int served;
      served = 0;
      forever begin
         wait (hold_requests > served);
         served++;
         rsp_hold = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   // result transfers against the oldest owed output
   always @(posedge clock) begin : check_outputs
      output_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_outputs.size() == 0) begin
            $error("unexpected output: out_sample %0d last_of_run %0b",
                   rsp_ch.out_sample, rsp_ch.last_of_run);
            mismatch_count++;
         end else begin
            want = owed_outputs.pop_front();
            if (rsp_ch.out_sample !== want.value) begin
               $error("out_sample expected %0d actual %0d", want.value, rsp_ch.out_sample);
               mismatch_count++;
            end
            if (rsp_ch.last_of_run !== want.last) begin
               $error("last_of_run expected %0b actual %0b", want.last, rsp_ch.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      row_type                         directed_rows[$];
      output_type                      none;
      logic [rsmp_pkg::COUNT_BITS-1:0] ic;
      logic [rsmp_pkg::COUNT_BITS-1:0] oc;
      logic [rsmp_pkg::COUNT_BITS-1:0] eff_ic;
      logic [rsmp_pkg::GAIN_BITS-1:0]  g;
      logic signed [SAMPLE_BITS-1:0]   s;
      int                              phase;
      int                              phase_items;
      bit                              dirty;

      req_ch.valid     <= 1'b0;
      req_ch.in_sample <= '0;
      csr_we           <= 1'b0;
      csr_index        <= rsmp_pkg::CSR_IN_COUNT;
      csr_wdata        <= '0;
      none             = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: unity after reset, saturation, ties, zero counts,
      // ratio limit, downsampling, counts changed mid-run
      directed_rows = '{
         known_row(24'h000000, 24'h000000, 1'b1),
         known_row(24'h7FFFFF, 24'h7FFFFF, 1'b1),
         known_row(24'h800000, 24'h800000, 1'b1),
         known_row(24'hFFFFFF, 24'hFFFFFF, 1'b1),
         sample_row(24'h000001),
         write_row(rsmp_pkg::CSR_GAIN, 16'hFFFF),
         known_row(24'h7FFFFF, 24'h7FFFFF, 1'b1),
         known_row(24'h800000, 24'h800000, 1'b1),
         sample_row(24'h000001),
         write_row(rsmp_pkg::CSR_GAIN, 16'h0000),
         known_row(24'h003039, 24'h000000, 1'b1),
         write_row(rsmp_pkg::CSR_GAIN, 16'd2048),
         sample_row(24'h000001),
         sample_row(24'hFFFFFF),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd0),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'd0),
         write_row(rsmp_pkg::CSR_GAIN, 16'd4096),
         sample_row(24'h123456),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd2),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'd128),
         sample_row(24'hABCDEF),
         sample_row(24'h000FFF),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd1),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'hFFFF),
         sample_row(24'h3C3C3C),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd5),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'd2),
         sample_row(24'h000001),
         sample_row(24'h000002),
         sample_row(24'h000003),
         sample_row(24'h000004),
         sample_row(24'h000005),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd4),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'd4),
         sample_row(24'h400000),
         sample_row(24'hC00000),
         write_row(rsmp_pkg::CSR_IN_COUNT, 16'd3),
         write_row(rsmp_pkg::CSR_OUT_COUNT, 16'd6),
         sample_row(24'h111111),
         sample_row(24'h222222),
         sample_row(24'hEEEEEE)
      };

      dirty = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (dirty) drain_outputs();
            dirty = 1'b0;
            write_reg(directed_rows[i].reg_index, directed_rows[i].wdata);
         end else begin
            offer_sample(directed_rows[i].sample, directed_rows[i].typed,
                         directed_rows[i].typed_out);
            dirty = 1'b1;
         end
      end

      // random phases of runs
      phase = 0;
      while (items_sent < ITEMS_WANTED) begin
         drain_outputs();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase

         case ($urandom_range(3))
            0: g = 16'h0000;
            1: g = 16'hFFFF;
            2: g = 16'd4096;
            default: g = 16'($urandom_range(0, 65535));
         endcase

         case ($urandom_range(9))
            0: begin ic = 16'd1; oc = 16'd1; end
            1: begin
               ic = 16'($urandom_range(1, 8));
               oc = 16'(ic * $urandom_range(1, 64));
            end
            2: begin ic = 16'($urandom_range(1, 16)); oc = 16'($urandom_range(1, ic)); end
            3: begin ic = 16'($urandom_range(1, 4)); oc = 16'($urandom_range(1, 64 * ic)); end
            4: begin ic = 16'($urandom_range(0, 1)); oc = 16'd0; end
            // more than the ratio limit from a single source sample
            5: begin ic = 16'd1; oc = 16'($urandom_range(65, 65535)); end
            6: begin ic = 16'hFFFF; oc = 16'hFFFF; end
            // owed outputs carried over to the following samples
            7: begin
               ic = 16'($urandom_range(2, 8));
               oc = 16'(64 * ic + $urandom_range(1, 200));
            end
            8: begin ic = 16'hFFFF; oc = 16'($urandom_range(1, 100)); end
            default: begin
               ic = 16'($urandom_range(1, 32));
               oc = 16'($urandom_range(1, 64 * ic));
            end
         endcase

         // back-pressure phase: receiver holds off while samples keep coming
         if (phase == 2) begin
            ic = 16'd3;
            oc = 16'd6;
         end

         write_reg(rsmp_pkg::CSR_IN_COUNT, ic);
         write_reg(rsmp_pkg::CSR_OUT_COUNT, oc);
         write_reg(rsmp_pkg::CSR_GAIN, g);

         // whole runs mostly, now and then a broken one
         eff_ic = (ic == '0) ? 16'd1 : ic;
         if (eff_ic <= 32) phase_items = ((24 + eff_ic - 1) / eff_ic) * eff_ic;
         else phase_items = 32;
         if ($urandom_range(4) == 0) phase_items += $urandom_range(1, 3);

         if (phase == 2) hold_requests++;

         repeat (phase_items) begin
            case ($urandom_range(7))
               0: s = 24'h7FFFFF;
               1: s = 24'h800000;
               2: begin
                  s = 24'($urandom_range(0, 2047));
                  if ($urandom_range(1) == 1) s = -s;
               end
               default: s = 24'($urandom());
            endcase
            offer_sample(s, 1'b0, none);
         end
         phase++;
      end

      drain_outputs();
      if (owed_outputs.size() != 0)
         $error("%0d expected outputs never arrived", owed_outputs.size());
      if (mismatch_count == 0 && owed_outputs.size() == 0) begin
         $display("tb_nearest_neighbor_resampler OK");
      end else begin
         $display("tb_nearest_neighbor_resampler NOT OK");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #3_000_000;
      $display("tb_nearest_neighbor_resampler NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
sv/rsmp_pkg.sv
sv/rsmp_if.sv
sv/rsmp_fifo.sv
sv/rsmp_front.sv
sv/rsmp_div.sv
sv/rsmp_back.sv
sv/nearest_neighbor_resampler.sv
tb/tb_nearest_neighbor_resampler.sv
